FILE: rtl/core/byte_stream_tokenizer_core_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef BYTE_STREAM_TOKENIZER_CORE_MACROS_SVH
`define BYTE_STREAM_TOKENIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define BSTC_ASSERT_IMPL(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");
// Next-cycle implication, disabled during reset.
`define BSTC_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");
`else
`define BSTC_ASSERT_IMPL(label, clock, reset, ante, cons)
`define BSTC_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif

`endif

FILE: rtl/core/bst_pkg.sv
// Shared types, constants and character classes for the byte stream tokenizer.
package bst_pkg;

  // Offset and identifier length counter widths
  localparam int OFFSET_BITS = 32;
  localparam int LENGTH_BITS = 16;
  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

  // Largest integer value before overflow
  localparam logic [34:0] NUM_MAX = 35'h0_7FFF_FFFF;

  // Token queue sizing
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_FILL_BITS = QUEUE_PTR_BITS + 1;

  // Output bus widths
  localparam int TDATA_BITS = 136;
  localparam int TUSER_BITS = 3;

  // Token kinds
  localparam logic [2:0] KIND_END     = 3'd0;
  localparam logic [2:0] KIND_SINGLE  = 3'd1;
  localparam logic [2:0] KIND_DOUBLE  = 3'd2;
  localparam logic [2:0] KIND_INTEGER = 3'd3;
  localparam logic [2:0] KIND_IDENT   = 3'd4;
  localparam logic [2:0] KIND_KEYWORD = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  // Error causes
  localparam logic CAUSE_ILLEGAL  = 1'b0;
  localparam logic CAUSE_OVERFLOW = 1'b1;

  // Keywords: text packed with the first byte lowest, and length
  localparam int KW_COUNT = 7;
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_0074_656c,  // let
    64'h0000_006b_6165_7262,  // break
    64'h6575_6e69_746e_6f63,  // continue
    64'h0000_6e72_7574_6572,  // return
    64'h0000_0000_706f_6f6c,  // loop
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6573_6c65   // else
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd8, 4'd6, 4'd4, 4'd2, 4'd4
  };

  // Special characters
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_BAR     = 8'h7c;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3d;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_LESS    = 8'h3c;
  localparam logic [7:0] CH_GREATER = 8'h3e;

  // One token as it leaves the block
  typedef struct packed {
    logic [2:0]  token_kind;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic [30:0] number_value;
    logic [2:0]  keyword_index;
    logic [31:0] ident_start;
    logic [15:0] ident_length;
    logic [31:0] line_number;
    logic        error_cause;
    logic        last_of_run;
  } token_t;

  // Tokens pushed into the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    token_t     slot0;
    token_t     slot1;
  } token_push_t;

  function automatic logic is_numeral(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a)) || (b == 8'h5f);
  endfunction

  // Space, newline, tab, CR, VT, FF
  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h0a) || (b == 8'h09) || (b == 8'h0d) ||
           (b == 8'h0b) || (b == 8'h0c);
  endfunction

  // Single-character tokens: ; ~ ^ * % ( ) : { } [ ] + - ,
  function automatic logic is_mono(input logic [7:0] b);
    return (b == 8'h3b) || (b == 8'h7e) || (b == 8'h5e) || (b == 8'h2a) ||
           (b == 8'h25) || (b == 8'h28) || (b == 8'h29) || (b == 8'h3a) ||
           (b == 8'h7b) || (b == 8'h7d) || (b == 8'h5b) || (b == 8'h5d) ||
           (b == 8'h2b) || (b == 8'h2d) || (b == 8'h2c);
  endfunction

  function automatic logic is_opch(input logic [7:0] b);
    return (b == CH_SLASH) || (b == CH_BAR) || (b == CH_AMP) || (b == CH_EQUAL) ||
           (b == CH_BANG) || (b == CH_LESS) || (b == CH_GREATER);
  endfunction

  // Second character that completes a two-character operator
  function automatic logic pairs(input logic [7:0] p, input logic [7:0] b);
    logic ok;
    ok = 1'b0;
    if (p == CH_BAR) ok = (b == CH_BAR);
    else if (p == CH_AMP) ok = (b == CH_AMP);
    else if ((p == CH_EQUAL) || (p == CH_BANG)) ok = (b == CH_EQUAL);
    else if (p == CH_LESS) ok = (b == CH_LESS) || (b == CH_EQUAL);
    else if (p == CH_GREATER) ok = (b == CH_GREATER) || (b == CH_EQUAL);
    return ok;
  endfunction

endpackage

FILE: rtl/core/bst_token_queue.sv
// Small token queue: takes up to two tokens a cycle, hands out one.
`include "byte_stream_tokenizer_core_macros.svh"

module bst_token_queue (
  input  logic                clk,
  input  logic                rst,
  input  bst_pkg::token_push_t push,
  input  logic                pop,
  output logic                room,
  output logic                head_valid,
  output bst_pkg::token_t     head
);

  bst_pkg::token_t entries [bst_pkg::QUEUE_DEPTH];
  logic [bst_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr;
  logic [bst_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr;
  logic [bst_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_plus;
  logic [bst_pkg::QUEUE_FILL_BITS-1:0] fill;
  logic [bst_pkg::QUEUE_FILL_BITS-1:0] fill_next;

  // Accept a byte only when two slots are free
  assign room        = fill <= bst_pkg::QUEUE_FILL_BITS'(bst_pkg::QUEUE_DEPTH - 2);
  assign head_valid  = fill != '0;
  assign head        = entries[rd_ptr];
  assign wr_ptr_plus = wr_ptr + bst_pkg::QUEUE_PTR_BITS'(1);
  assign fill_next   = fill + bst_pkg::QUEUE_FILL_BITS'(push.count)
                            - bst_pkg::QUEUE_FILL_BITS'(pop);

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      fill   <= fill_next;
      wr_ptr <= wr_ptr + bst_pkg::QUEUE_PTR_BITS'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + bst_pkg::QUEUE_PTR_BITS'(1);
      end
    end
  end

  // Store pushed tokens
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.slot0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus] <= push.slot1;
    end
  end

  `BSTC_ASSERT_IMPL(fill_bound, clk, rst, 1'b1, fill <= bst_pkg::QUEUE_FILL_BITS'(bst_pkg::QUEUE_DEPTH))
  `BSTC_ASSERT_NEXT(double_push_grows, clk, rst, push.count == 2'd2 && !pop, fill == $past(fill) + bst_pkg::QUEUE_FILL_BITS'(2))
  `BSTC_ASSERT_IMPL(push_needs_room, clk, rst, push.count != 2'd0, room)

endmodule

FILE: rtl/core/byte_stream_tokenizer_core.sv
// Byte stream tokenizer: one source byte an item in, tokens out through a small queue.
// Takes one source byte per cycle while two queue slots are free, and emits up to two
// tokens for it (a number, identifier or lone operator ends when the byte after it
// arrives, and that byte may start or be a token itself). Each byte is decoded in the
// cycle it is accepted against the scan state, and its tokens go into a four-entry
// token queue; the input waits once the queue holds more than two tokens, even while
// the output keeps taking one token a cycle. The sustained rate is one byte per cycle,
// lowered to one token per cycle by the queue's single output port when bytes cause
// two tokens; a token reaches the output the cycle after the byte that ends it if the
// queue was empty. Output tdata carries the token fields, tuser the token kind, tlast
// the last token caused by a byte.
`include "byte_stream_tokenizer_core_macros.svh"

module byte_stream_tokenizer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // source_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // first_char, second_char, number_value, keyword_index, ident_start,
  // ident_length, line_number, error_cause, zero fill
  output logic [bst_pkg::TDATA_BITS-1:0] m_axis_tdata,
  output logic [bst_pkg::TUSER_BITS-1:0] m_axis_tuser,   // token_kind
  output logic                            m_axis_tlast    // last_of_run
);

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_NUM     = 5'b00010,
    MODE_IDENT   = 5'b00100,
    MODE_OP      = 5'b01000,
    MODE_COMMENT = 5'b10000
  } mode_t;

  mode_t                             mode, mode_next;
  logic [7:0]                        pending_char, pending_char_next;
  logic [30:0]                       number_accumulator, number_accumulator_next;
  logic                              overflow_seen, overflow_seen_next;
  logic [63:0]                       ident_prefix, ident_prefix_next;
  logic [bst_pkg::LENGTH_BITS-1:0]   ident_count, ident_count_next;
  logic [bst_pkg::OFFSET_BITS-1:0]   ident_begin, ident_begin_next;
  logic [bst_pkg::OFFSET_BITS-1:0]   byte_offset;
  logic [31:0]                       line_count, line_count_next;

  logic                  accept;
  logic [7:0]            b;
  logic [34:0]           num_product;
  logic                  run_idle;
  logic                  lead_valid;
  logic                  idle_valid;
  bst_pkg::token_t       blank;
  bst_pkg::token_t       lead;
  bst_pkg::token_t       idle_tok;
  bst_pkg::token_t       ident_tok;
  bst_pkg::token_push_t  push;
  logic                  room;
  logic                  head_valid;
  bst_pkg::token_t       head;

  assign b      = s_axis_tdata;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room;

  // Times ten plus the new digit
  assign num_product = ({4'b0, number_accumulator} << 3) + ({4'b0, number_accumulator} << 1)
                     + {31'b0, b[3:0]};

  // Empty token carrying the current line
  always_comb begin
    blank = '0;
    blank.line_number = line_count;
  end

  // Finish an identifier: keyword or plain identifier
  always_comb begin
    ident_tok = blank;
    ident_tok.token_kind   = bst_pkg::KIND_IDENT;
    ident_tok.ident_start  = 32'(ident_begin);
    ident_tok.ident_length = 16'(ident_count);
    for (int k = 0; k < bst_pkg::KW_COUNT; k++) begin
      if ((ident_count == bst_pkg::LENGTH_BITS'(bst_pkg::KW_LEN[k])) &&
          (ident_prefix == bst_pkg::KW_TEXT[k])) begin
        ident_tok = blank;
        ident_tok.token_kind    = bst_pkg::KIND_KEYWORD;
        ident_tok.keyword_index = 3'(k);
      end
    end
  end

  // Scan one byte against the current mode
  always_comb begin
    mode_next               = mode;
    pending_char_next       = pending_char;
    number_accumulator_next = number_accumulator;
    overflow_seen_next      = overflow_seen;
    ident_prefix_next       = ident_prefix;
    ident_count_next        = ident_count;
    ident_begin_next        = ident_begin;
    line_count_next         = line_count;
    run_idle   = 1'b0;
    lead_valid = 1'b0;
    lead       = blank;
    idle_valid = 1'b0;
    idle_tok   = blank;

    unique case (mode)
      MODE_NUM: begin
        if (bst_pkg::is_numeral(b)) begin
          if (overflow_seen || (num_product > bst_pkg::NUM_MAX)) begin
            overflow_seen_next = 1'b1;
          end else begin
            number_accumulator_next = num_product[30:0];
          end
        end else begin
          lead_valid = 1'b1;
          if (overflow_seen) begin
            lead.token_kind  = bst_pkg::KIND_ERROR;
            lead.error_cause = bst_pkg::CAUSE_OVERFLOW;
          end else begin
            lead.token_kind   = bst_pkg::KIND_INTEGER;
            lead.number_value = number_accumulator;
          end
          run_idle = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (bst_pkg::is_alpha(b) || bst_pkg::is_numeral(b)) begin
          if (ident_count < bst_pkg::LENGTH_BITS'(8)) begin
            ident_prefix_next[{ident_count[2:0], 3'b000} +: 8] = b;
          end
          if (ident_count != bst_pkg::LENGTH_MAX) begin
            ident_count_next = ident_count + bst_pkg::LENGTH_BITS'(1);
          end
        end else begin
          lead_valid = 1'b1;
          lead       = ident_tok;
          run_idle   = 1'b1;
        end
      end
      MODE_OP: begin
        if ((pending_char == bst_pkg::CH_SLASH) && (b == bst_pkg::CH_SLASH)) begin
          mode_next = MODE_COMMENT;
        end else if (bst_pkg::pairs(pending_char, b)) begin
          lead_valid = 1'b1;
          lead.token_kind  = bst_pkg::KIND_DOUBLE;
          lead.first_char  = pending_char;
          lead.second_char = b;
          mode_next = MODE_IDLE;
        end else begin
          lead_valid = 1'b1;
          lead.token_kind = bst_pkg::KIND_SINGLE;
          lead.first_char = pending_char;
          run_idle = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if ((b == bst_pkg::CH_NUL) || (b == bst_pkg::CH_NEWLINE)) begin
          run_idle = 1'b1;
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    // Start of a new token, or a token of its own
    if (run_idle) begin
      mode_next = MODE_IDLE;
      if (b == bst_pkg::CH_NUL) begin
        idle_valid = 1'b1;
        idle_tok.token_kind = bst_pkg::KIND_END;
      end else if (bst_pkg::is_space(b)) begin
        if (b == bst_pkg::CH_NEWLINE) begin
          line_count_next = line_count + 32'd1;
        end
      end else if (bst_pkg::is_mono(b)) begin
        idle_valid = 1'b1;
        idle_tok.token_kind = bst_pkg::KIND_SINGLE;
        idle_tok.first_char = b;
      end else if (bst_pkg::is_numeral(b)) begin
        mode_next               = MODE_NUM;
        number_accumulator_next = {27'b0, b[3:0]};
        overflow_seen_next      = 1'b0;
      end else if (bst_pkg::is_alpha(b)) begin
        mode_next         = MODE_IDENT;
        ident_prefix_next = {56'b0, b};
        ident_count_next  = bst_pkg::LENGTH_BITS'(1);
        ident_begin_next  = byte_offset;
      end else if (bst_pkg::is_opch(b)) begin
        mode_next         = MODE_OP;
        pending_char_next = b;
      end else begin
        idle_valid = 1'b1;
        idle_tok.token_kind  = bst_pkg::KIND_ERROR;
        idle_tok.error_cause = bst_pkg::CAUSE_ILLEGAL;
        idle_tok.first_char  = b;
      end
    end
  end

  // Pack the byte's tokens in order and mark the last one
  always_comb begin
    push.count = accept ? (2'(lead_valid) + 2'(idle_valid)) : 2'd0;
    push.slot0 = lead_valid ? lead : idle_tok;
    push.slot1 = idle_tok;
    push.slot0.last_of_run = !(lead_valid && idle_valid);
    push.slot1.last_of_run = 1'b1;
  end

  // Update the scan state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_IDLE;
      pending_char       <= '0;
      number_accumulator <= '0;
      overflow_seen      <= 1'b0;
      ident_prefix       <= '0;
      ident_count        <= '0;
      ident_begin        <= '0;
      byte_offset        <= '0;
      line_count         <= '0;
    end else if (accept) begin
      mode               <= mode_next;
      pending_char       <= pending_char_next;
      number_accumulator <= number_accumulator_next;
      overflow_seen      <= overflow_seen_next;
      ident_prefix       <= ident_prefix_next;
      ident_count        <= ident_count_next;
      ident_begin        <= ident_begin_next;
      byte_offset        <= byte_offset + bst_pkg::OFFSET_BITS'(1);
      line_count         <= line_count_next;
    end
  end

  bst_token_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (m_axis_tready && head_valid),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  // Drive the output bus from the queue head
  assign m_axis_tvalid = head_valid;
  assign m_axis_tuser  = head.token_kind;
  assign m_axis_tlast  = head.last_of_run;
  assign m_axis_tdata  = {5'b0, head.error_cause, head.line_number, head.ident_length,
                          head.ident_start, head.keyword_index, head.number_value,
                          head.second_char, head.first_char};

  `BSTC_ASSERT_IMPL(nul_gives_token, clk, rst, accept && b == bst_pkg::CH_NUL, push.count != 2'd0)
  `BSTC_ASSERT_IMPL(digit_run_silent, clk, rst, accept && mode == MODE_NUM && bst_pkg::is_numeral(b), push.count == 2'd0)
  `BSTC_ASSERT_NEXT(newline_counts, clk, rst, accept && mode == MODE_IDLE && b == bst_pkg::CH_NEWLINE, line_count == $past(line_count) + 32'd1)

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the byte stream tokenizer core.
`timescale 1ns / 100ps

module tb;

  // Scan states and character classes of the token predictor
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_NUMBER, SCAN_IDENT, SCAN_OPERATOR, SCAN_COMMENT
  } scan_t;

  typedef enum logic [2:0] {
    CL_OTHER, CL_SPACE, CL_MONO, CL_DIGIT, CL_ALPHA, CL_OPER
  } char_class_t;

  localparam string MONO_CHARS = ";~^*%():{}[]+-,";
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [34:0] INT_LIMIT = 35'h0_7FFF_FFFF;
  localparam int LONG_IDENT = 40;
  localparam int SOURCE_BYTES = 950;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = 8'h00;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [bst_pkg::TDATA_BITS-1:0] m_axis_tdata;
  logic [bst_pkg::TUSER_BITS-1:0] m_axis_tuser;
  logic                           m_axis_tlast;

  byte_stream_tokenizer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk = ~clk;

  string kw_names [7] = '{"let", "break", "continue", "return", "loop", "if", "else"};
  string op_texts [24] = '{"/", "|", "&", "=", "!", "<", ">", "||", "&&", "==", "!=",
                           "<<", "<=", ">>", ">=", "/=", "=<", "!!", "&|", "|&", "<>",
                           "><", "=!", "/*"};
  logic [7:0] blank_chars [6] = '{8'h20, 8'h09, 8'h0d, 8'h0b, 8'h0c, 8'h0a};

  // Source bytes waiting to be sent, tokens waiting to come out
  logic [7:0]      src_q [$];
  bst_pkg::token_t token_q [$];
  bst_pkg::token_t step_toks [$];

  // Tokenizer state as predicted
  scan_t       mode = SCAN_IDLE;
  logic [7:0]  op_char = '0;
  logic [30:0] num_acc = '0;
  logic        num_ovf = 1'b0;
  logic [63:0] id_text = '0;
  logic [15:0] id_len = '0;
  logic [31:0] id_first = '0;
  logic [31:0] pos = '0;
  logic [31:0] lines = '0;

  int              bytes_taken = 0;
  int              errs = 0;
  int              shown = 0;
  int              src_wait = 0, src_calm = 0, src_gap;
  int              sink_wait = 0, sink_calm = 0, sink_gap;
  int              idle_cycles = 0;
  bst_pkg::token_t seen;

  function automatic char_class_t char_class(logic [7:0] b);
    char_class_t c;
    c = CL_OTHER;
    if (b == CH_SPACE || (b >= 8'h09 && b <= 8'h0d)) c = CL_SPACE;
    else if (b >= "0" && b <= "9") c = CL_DIGIT;
    else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_") c = CL_ALPHA;
    else if (b == bst_pkg::CH_SLASH || b == bst_pkg::CH_BAR || b == bst_pkg::CH_AMP ||
             b == bst_pkg::CH_EQUAL || b == bst_pkg::CH_BANG || b == bst_pkg::CH_LESS ||
             b == bst_pkg::CH_GREATER) c = CL_OPER;
    else begin
      for (int i = 0; i < MONO_CHARS.len(); i++)
        if (b == MONO_CHARS[i]) c = CL_MONO;
    end
    return c;
  endfunction

  // Does b complete a two-character operator started by p
  function automatic bit op_pairs(logic [7:0] p, logic [7:0] b);
    case (p)
      bst_pkg::CH_BAR:     return b == bst_pkg::CH_BAR;
      bst_pkg::CH_AMP:     return b == bst_pkg::CH_AMP;
      bst_pkg::CH_EQUAL,
      bst_pkg::CH_BANG:    return b == bst_pkg::CH_EQUAL;
      bst_pkg::CH_LESS:    return b == bst_pkg::CH_LESS || b == bst_pkg::CH_EQUAL;
      bst_pkg::CH_GREATER: return b == bst_pkg::CH_GREATER || b == bst_pkg::CH_EQUAL;
      default:             return 1'b0;
    endcase
  endfunction

  function automatic void add_token(logic [2:0] kind, logic [7:0] c1, logic [7:0] c2,
                                    logic [30:0] num, logic [2:0] kw, logic [31:0] start,
                                    logic [15:0] len, logic cause);
    bst_pkg::token_t t;
    t.token_kind    = kind;
    t.first_char    = c1;
    t.second_char   = c2;
    t.number_value  = num;
    t.keyword_index = kw;
    t.ident_start   = start;
    t.ident_length  = len;
    t.line_number   = lines;
    t.error_cause   = cause;
    t.last_of_run   = 1'b0;
    step_toks.insert(step_toks.size(), t);
  endfunction

  function automatic void close_number();
    if (num_ovf) add_token(bst_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0, bst_pkg::CAUSE_OVERFLOW);
    else add_token(bst_pkg::KIND_INTEGER, 0, 0, num_acc, 0, 0, 0, bst_pkg::CAUSE_ILLEGAL);
    mode = SCAN_IDLE;
  endfunction

  // Keywords match on exact length and the packed first eight bytes
  function automatic void close_ident();
    logic [63:0] word;
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < 7; k++) begin
      word = '0;
      for (int i = 0; i < kw_names[k].len(); i++) word[8*i +: 8] = kw_names[k][i];
      if (!hit && id_len == 16'(kw_names[k].len()) && id_text == word) begin
        add_token(bst_pkg::KIND_KEYWORD, 0, 0, 0, 3'(k), 0, 0, bst_pkg::CAUSE_ILLEGAL);
        hit = 1'b1;
      end
    end
    if (!hit) begin
      add_token(bst_pkg::KIND_IDENT, 0, 0, 0, 0, id_first, id_len, bst_pkg::CAUSE_ILLEGAL);
    end
    mode = SCAN_IDLE;
  endfunction

  // Scan a byte with no token in progress
  function automatic void start_byte(logic [7:0] b);
    mode = SCAN_IDLE;
    if (b == bst_pkg::CH_NUL) begin
      add_token(bst_pkg::KIND_END, 0, 0, 0, 0, 0, 0, bst_pkg::CAUSE_ILLEGAL);
    end else begin
      case (char_class(b))
        CL_SPACE: if (b == bst_pkg::CH_NEWLINE) lines++;
        CL_MONO:  add_token(bst_pkg::KIND_SINGLE, b, 0, 0, 0, 0, 0, bst_pkg::CAUSE_ILLEGAL);
        CL_DIGIT: begin
          mode = SCAN_NUMBER;
          num_acc = 31'(b - CH_ZERO);
          num_ovf = 1'b0;
        end
        CL_ALPHA: begin
          mode = SCAN_IDENT;
          id_text = {56'h0, b};
          id_len = 16'd1;
          id_first = pos;
        end
        CL_OPER: begin
          mode = SCAN_OPERATOR;
          op_char = b;
        end
        default: add_token(bst_pkg::KIND_ERROR, b, 0, 0, 0, 0, 0, bst_pkg::CAUSE_ILLEGAL);
      endcase
    end
  endfunction

  // Advance the predicted tokenizer by one byte and queue the tokens it ends
  function automatic void predict_byte(logic [7:0] b);
    logic [34:0] grown;
    bst_pkg::token_t t;
    case (mode)
      SCAN_NUMBER: begin
        if (char_class(b) == CL_DIGIT) begin
          grown = 35'(num_acc) * 35'd10 + 35'(b - CH_ZERO);
          if (num_ovf || grown > INT_LIMIT) num_ovf = 1'b1;
          else num_acc = grown[30:0];
        end else begin
          close_number();
          start_byte(b);
        end
      end
      SCAN_IDENT: begin
        if (char_class(b) == CL_ALPHA || char_class(b) == CL_DIGIT) begin
          if (id_len < 16'd8) id_text = id_text | (64'(b) << (8 * id_len));
          if (id_len != bst_pkg::LENGTH_MAX) id_len++;
        end else begin
          close_ident();
          start_byte(b);
        end
      end
      SCAN_OPERATOR: begin
        if (op_char == bst_pkg::CH_SLASH && b == bst_pkg::CH_SLASH) begin
          mode = SCAN_COMMENT;
        end else if (op_pairs(op_char, b)) begin
          add_token(bst_pkg::KIND_DOUBLE, op_char, b, 0, 0, 0, 0, bst_pkg::CAUSE_ILLEGAL);
          mode = SCAN_IDLE;
        end else begin
          add_token(bst_pkg::KIND_SINGLE, op_char, 0, 0, 0, 0, 0, bst_pkg::CAUSE_ILLEGAL);
          start_byte(b);
        end
      end
      SCAN_COMMENT: if (b == bst_pkg::CH_NUL || b == bst_pkg::CH_NEWLINE) start_byte(b);
      default: start_byte(b);
    endcase
    pos++;
    // Mark the last token of this byte
    if (step_toks.size() != 0) begin
      t = step_toks.pop_back();
      t.last_of_run = 1'b1;
      step_toks.insert(step_toks.size(), t);
    end
    while (step_toks.size() != 0) token_q.insert(token_q.size(), step_toks.pop_front());
  endfunction

  // Per-item wait drawn at random, with occasional stretches of none
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  function automatic void put(logic [7:0] b);
    src_q.insert(src_q.size(), b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic logic [7:0] id_char(bit lead);
    int r;
    r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  // Append one random lexeme, mostly well formed, then maybe a separator
  function automatic void put_fragment();
    int pick, n;
    logic [7:0] b;
    string word;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      case ($urandom_range(0, 6))
        0: put_text($sformatf("%0d", $urandom_range(0, 9)));
        1: put_text($sformatf("%0d", $urandom_range(0, 99999)));
        2: put_text($sformatf("%0d", $urandom() >> 1));
        3: put_text("2147483647");
        4: put_text($sformatf("%0d", 64'd2147483648 + 64'($urandom_range(0, 1000))));
        5: begin
          n = $urandom_range(11, 16);
          repeat (n) put(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        default: put_text($sformatf("000%0d", $urandom_range(0, 500)));
      endcase
    end else if (pick < 40) begin
      word = kw_names[$urandom_range(0, 6)];
      case ($urandom_range(0, 4))
        0, 1: put_text(word);
        2: begin
          put_text(word);
          put(id_char(1'b0));
        end
        3: put_text(word.substr(0, word.len() - 2));
        default: begin
          n = $urandom_range(1, 12);
          put(id_char(1'b1));
          repeat (n - 1) put(id_char(1'b0));
        end
      endcase
    end else if (pick < 52) begin
      put(MONO_CHARS[$urandom_range(0, 14)]);
    end else if (pick < 68) begin
      put_text(op_texts[$urandom_range(0, 23)]);
    end else if (pick < 76) begin
      put_text("//");
      n = $urandom_range(0, 20);
      repeat (n) begin
        do b = 8'($urandom_range(1, 255)); while (b == bst_pkg::CH_NEWLINE);
        put(b);
      end
      put(($urandom_range(0, 9) == 0) ? bst_pkg::CH_NUL : bst_pkg::CH_NEWLINE);
    end else if (pick < 86) begin
      n = $urandom_range(1, 3);
      repeat (n) put(blank_chars[$urandom_range(0, 5)]);
    end else if (pick < 92) begin
      do b = 8'($urandom_range(1, 255)); while (char_class(b) != CL_OTHER);
      put(b);
    end else if (pick < 95) begin
      put(bst_pkg::CH_NUL);
    end else begin
      put(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1) == 1) put(blank_chars[$urandom_range(0, 5)]);
  endfunction

  // Send source bytes from the queue, predicting tokens as each item is taken
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_wait <= 0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      predict_byte(s_axis_tdata);
      bytes_taken++;
      src_gap = draw_wait(src_calm);
      if (src_gap == 0 && src_q.size() != 0) begin
        s_axis_tdata <= src_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
        src_wait <= (src_gap > 0) ? src_gap - 1 : 0;
      end
    end else if (!s_axis_tvalid) begin
      if (src_wait > 0) begin
        src_wait <= src_wait - 1;
      end else if (src_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= src_q.pop_front();
      end
    end
  end

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errs++;
      if (shown < 10) begin
        shown++;
        $display("token mismatch on %s: expected %0h, got %0h", fname, want, got);
      end
    end
  endtask

  // Compare a token against the oldest expectation
  task automatic check_token(bst_pkg::token_t got);
    bst_pkg::token_t want;
    if (token_q.size() == 0) begin
      errs++;
      if (shown < 10) begin
        shown++;
        $display("unexpected token: kind %0d first_char %0h", got.token_kind, got.first_char);
      end
      return;
    end
    want = token_q.pop_front();
    check_field("token_kind", 32'(want.token_kind), 32'(got.token_kind));
    check_field("first_char", 32'(want.first_char), 32'(got.first_char));
    check_field("second_char", 32'(want.second_char), 32'(got.second_char));
    check_field("number_value", 32'(want.number_value), 32'(got.number_value));
    check_field("keyword_index", 32'(want.keyword_index), 32'(got.keyword_index));
    check_field("ident_start", want.ident_start, got.ident_start);
    check_field("ident_length", 32'(want.ident_length), 32'(got.ident_length));
    check_field("line_number", want.line_number, got.line_number);
    check_field("error_cause", 32'(want.error_cause), 32'(got.error_cause));
    check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
  endtask

  // Take tokens with random stalls and check each one
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      seen.token_kind    = m_axis_tuser;
      seen.first_char    = m_axis_tdata[7:0];
      seen.second_char   = m_axis_tdata[15:8];
      seen.number_value  = m_axis_tdata[46:16];
      seen.keyword_index = m_axis_tdata[49:47];
      seen.ident_start   = m_axis_tdata[81:50];
      seen.ident_length  = m_axis_tdata[97:82];
      seen.line_number   = m_axis_tdata[129:98];
      seen.error_cause   = m_axis_tdata[130];
      seen.last_of_run   = m_axis_tlast;
      check_token(seen);
      sink_gap = draw_wait(sink_calm);
      if (sink_gap != 0) begin
        m_axis_tready <= 1'b0;
        sink_wait <= sink_gap - 1;
      end
    end else if (!m_axis_tready) begin
      if (sink_wait > 0) sink_wait <= sink_wait - 1;
      else m_axis_tready <= 1'b1;
    end
  end

  // End the run if neither side moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int total;
    // Keyword, operator pair, number, comment, overflow into an illegal byte, end
    put_text("if a>=9 //c\n");
    put_text("2147483648");
    put(8'hFF);
    put(bst_pkg::CH_NUL);
    while (src_q.size() < SOURCE_BYTES / 2) put_fragment();
    // One identifier well past the eight bytes kept for keyword matching
    put(id_char(1'b1));
    repeat (LONG_IDENT) put(id_char(1'b0));
    put(CH_SPACE);
    while (src_q.size() < SOURCE_BYTES) put_fragment();
    put(bst_pkg::CH_NUL);
    total = src_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken != total) @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errs == 0 && token_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: byte_stream_tokenizer_core.f
+incdir+rtl/core
rtl/core/bst_pkg.sv
rtl/core/bst_token_queue.sv
rtl/core/byte_stream_tokenizer_core.sv
tb/tb.sv
